### src/sle_pkg.sv
// shared types, constants and codes of the sequential list engine
package sle_pkg;

    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 7;
    localparam int KIND_W     = 3;

    typedef logic [ELEM_WIDTH-1:0] t_elem;
    typedef logic [COUNT_W-1:0]    t_count;

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR  = 3'd0,
        K_GET    = 3'd1,
        K_LOCATE = 3'd2,
        K_PRIOR  = 3'd3,
        K_NEXT   = 3'd4,
        K_INSERT = 3'd5,
        K_DELETE = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_status status;
        t_elem   data;
        t_count  fpos;
        t_count  count;
        logic    empty;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_done;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_elem             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_elem  a;
        t_elem  b;
        t_count idx;
        logic   down;
    } t_alu_req;

    typedef struct packed {
        logic   eq;
        t_count idx_nx;
    } t_alu_rsp;

endpackage

### src/sle_ram.sv
// generic single write port, single read port ram with registered read
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sle_alu.sv
// shared compare and index step unit
module sle_alu
    import sle_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    always_comb begin
        o_rsp.eq     = (i_req.a == i_req.b);
        o_rsp.idx_nx = i_req.down ? (i_req.idx - t_count'(1)) : (i_req.idx + t_count'(1));
    end

endmodule

### src/sle_seq.sv
// sequencer that walks the element store one entry at a time
module sle_seq
    import sle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [POS_W-1:0]  i_pos,
    input  t_elem             i_val,
    output t_done             o_done,
    input  logic              i_done_ready,
    output t_ram_req          o_ram,
    input  t_elem             i_rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EV   = 5'b00100,
        S_WR   = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    t_kind   r_kind, n_kind;
    t_count  r_pos, n_pos;
    t_elem   r_val, n_val;
    t_count  r_len, n_len;
    t_count  r_idx, n_idx;
    t_elem   r_prev, n_prev;
    logic    r_hit, n_hit;
    t_status r_status, n_status;
    t_elem   r_data, n_data;
    t_count  r_fpos, n_fpos;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    t_count   pos_m1;
    t_count   in_pos_m1;
    logic     last;

    sle_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign pos_m1    = r_pos - t_count'(1);
    assign in_pos_m1 = t_count'(i_pos) - t_count'(1);
    assign last      = (alu_rsp.idx_nx == r_len);

    always_comb begin
        alu_req.a    = i_rdata;
        alu_req.b    = r_val;
        alu_req.idx  = r_idx;
        alu_req.down = (r_kind == K_INSERT);
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_pos    = r_pos;
        n_val    = r_val;
        n_len    = r_len;
        n_idx    = r_idx;
        n_prev   = r_prev;
        n_hit    = r_hit;
        n_status = r_status;
        n_data   = r_data;
        n_fpos   = r_fpos;
        o_ready  = 1'b0;
        o_ram    = '0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind   = t_kind'(i_kind);
                    n_pos    = t_count'(i_pos);
                    n_val    = i_val;
                    n_status = ST_OK;
                    n_data   = '0;
                    n_fpos   = '0;
                    n_hit    = 1'b0;
                    n_state  = S_DONE;
                    case (t_kind'(i_kind))
                        K_CLEAR: begin
                            n_len = '0;
                        end
                        K_GET, K_DELETE: begin
                            if (i_pos == '0 || t_count'(i_pos) > r_len) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_idx   = in_pos_m1;
                                n_state = S_RD;
                            end
                        end
                        K_LOCATE, K_PRIOR, K_NEXT: begin
                            n_status = ST_NOTFOUND;
                            if (r_len != '0) begin
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        K_INSERT: begin
                            if (i_pos == '0 || in_pos_m1 > r_len) begin
                                n_status = ST_BADPOS;
                            end else if (r_len >= t_count'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = r_len;
                                // inserting at the tail needs no shift
                                n_state = (r_len == in_pos_m1) ? S_WR : S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = (r_kind == K_INSERT) ? alu_rsp.idx_nx[ADDR_W-1:0]
                                                   : r_idx[ADDR_W-1:0];
                n_state     = S_EV;
            end
            S_EV: begin
                n_state = S_RD;
                n_idx   = alu_rsp.idx_nx;
                case (r_kind)
                    K_GET: begin
                        n_data  = i_rdata;
                        n_state = S_DONE;
                    end
                    K_LOCATE: begin
                        if (alu_rsp.eq) begin
                            n_status = ST_OK;
                            n_fpos   = alu_rsp.idx_nx;
                            n_state  = S_DONE;
                        end else if (last) begin
                            n_state = S_DONE;
                        end
                    end
                    K_PRIOR: begin
                        n_prev = i_rdata;
                        if (r_idx != '0 && alu_rsp.eq) begin
                            n_status = ST_OK;
                            n_data   = r_prev;
                            n_state  = S_DONE;
                        end else if (last) begin
                            n_state = S_DONE;
                        end
                    end
                    K_NEXT: begin
                        // previous entry matched, this one is its successor
                        n_hit = alu_rsp.eq;
                        if (r_hit) begin
                            n_status = ST_OK;
                            n_data   = i_rdata;
                            n_state  = S_DONE;
                        end else if (last) begin
                            n_state = S_DONE;
                        end
                    end
                    K_INSERT: begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = r_idx[ADDR_W-1:0];
                        o_ram.wdata = i_rdata;
                        if (alu_rsp.idx_nx == pos_m1) begin
                            n_state = S_WR;
                        end
                    end
                    K_DELETE: begin
                        if (r_idx == pos_m1) begin
                            n_data = i_rdata;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = ADDR_W'(r_idx - t_count'(1));
                            o_ram.wdata = i_rdata;
                        end
                        if (last) begin
                            n_len   = r_len - t_count'(1);
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = pos_m1[ADDR_W-1:0];
                o_ram.wdata = r_val;
                n_len       = r_len + t_count'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_done_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_done.valid      = (r_state == S_DONE);
        o_done.res.status = r_status;
        o_done.res.data   = r_data;
        o_done.res.fpos   = r_fpos;
        o_done.res.count  = r_len;
        o_done.res.empty  = (r_len == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_data   <= n_data;
        r_fpos   <= n_fpos;
    end

endmodule

### src/sequential_list_engine_top.sv
// top level of the sequential list engine
//
// an ordered list of up to 64 words kept in a single-port-per-direction ram.
// requests enter on the s_axis channel: tuser carries the request kind, tdata
// carries the 1-based position and the value. each request gives exactly one
// result item on the m_axis channel: tuser carries the status, tdata carries
// the data word, the found position, the element count and the empty flag.
// one request is in work at a time; s_axis_tready is low from acceptance
// until the result has moved into the output register.
// clear, errors, a full list, unused kinds and searches on an empty list
// go straight to the result; get reads one element, searches visit the
// elements from the head until a match or the tail, insert moves the
// elements from position p onward back by one and then writes the value,
// and delete returns element p and moves the elements behind it forward.
// every visited element takes a read state and then an evaluate state on
// the ram, whose read data is registered; shifts reuse the same states.
// reset clears the list length and the channels; the store needs no clearing.
// a stalled receiver holds the result in the output register; the next
// request is taken meanwhile and its own result waits behind it.
module sequential_list_engine_top
    import sle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // position[6:0], value[38:7], zero pad
    input  logic [2:0]  i_s_axis_tuser,  // kind[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // data_out[31:0], found_position[38:32],
                                         // list_count[45:39], is_empty[46], zero pad
    output logic [1:0]  o_m_axis_tuser   // status[1:0]
);

    t_done    done;
    t_ram_req ram_req;
    t_elem    rdata;
    logic     done_ready;
    logic     r_ovalid;
    t_result  r_ores;

    assign done_ready = !r_ovalid || i_m_axis_tready;

    sle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (i_s_axis_tuser),
        .i_pos        (i_s_axis_tdata[POS_W-1:0]),
        .i_val        (i_s_axis_tdata[POS_W+ELEM_WIDTH-1:POS_W]),
        .o_done       (done),
        .i_done_ready (done_ready),
        .o_ram        (ram_req),
        .i_rdata      (rdata)
    );

    sle_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done_ready) begin
            r_ovalid <= done.valid;
        end
        if (done_ready && done.valid) begin
            r_ores <= done.res;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ores.status;
    assign o_m_axis_tdata  = {1'b0, r_ores.empty, r_ores.count, r_ores.fpos, r_ores.data};

endmodule

### src/sle_checker.sv
// port-level checks of the sequential list engine and their binding
module sle_checker
    import sle_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready
);

    // a result held under backpressure does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // one request at a time: busy right after an item is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[46] == (o_m_axis_tdata[45:39] == 7'd0))
        else $error("empty flag disagrees with count");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[45:39] <= 7'(CAPACITY))
        else $error("count above capacity");

    // a found position is only reported on success
    a_fpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[38:32] != 7'd0 |-> o_m_axis_tuser == ST_OK)
        else $error("found position with failing status");

endmodule

bind sequential_list_engine_top sle_checker u_sle_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

### tb/sv/tb.sv
// self-checking testbench for the sequential list engine with a scoreboard and random stimulus
module tb;
    import sle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_UNUSED  = 3'd7;
    localparam int         RANDOM_ITEMS = 500;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int         CYCLE_LIMIT  = 600000;

    // list model: mirrors the stored words and length, queues predicted results
    class list_scoreboard;
        t_elem       elems[CAPACITY];
        int          len = 0;
        int          max_len = 0;
        t_result     pending_q[$];
        int unsigned n_errors = 0;
        int unsigned n_requests = 0;
        int unsigned n_checked = 0;
        int unsigned status_seen[4];

        function void note_request(logic [2:0] kind, logic [6:0] pos, t_elem val);
            t_result r;
            int      p;
            int      k;
            bit      hit;
            p = pos;
            hit = 1'b0;
            r = '0;
            r.status = ST_OK;
            case (kind)
                K_CLEAR: len = 0;
                K_GET: begin
                    if (p < 1 || p > len) r.status = ST_BADPOS;
                    else r.data = elems[p-1];
                end
                K_LOCATE: begin
                    r.status = ST_NOTFOUND;
                    for (k = 0; k < len && !hit; k++) begin
                        if (elems[k] == val) begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.fpos = t_count'(k + 1);
                        end
                    end
                end
                K_PRIOR: begin
                    // a match at the head has no predecessor
                    r.status = ST_NOTFOUND;
                    for (k = 1; k < len && !hit; k++) begin
                        if (elems[k] == val) begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.data = elems[k-1];
                        end
                    end
                end
                K_NEXT: begin
                    r.status = ST_NOTFOUND;
                    for (k = 0; k + 1 < len && !hit; k++) begin
                        if (elems[k] == val) begin
                            hit = 1'b1;
                            r.status = ST_OK;
                            r.data = elems[k+1];
                        end
                    end
                end
                K_INSERT: begin
                    // position is checked before the full condition
                    if (p < 1 || p > len + 1) begin
                        r.status = ST_BADPOS;
                    end else if (len >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (k = len; k > p - 1; k--) elems[k] = elems[k-1];
                        elems[p-1] = val;
                        len++;
                    end
                end
                K_DELETE: begin
                    if (p < 1 || p > len) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.data = elems[p-1];
                        for (k = p; k < len; k++) elems[k-1] = elems[k];
                        len--;
                    end
                end
                default: ;
            endcase
            r.count = len[6:0];
            r.empty = (len == 0);
            if (len > max_len) max_len = len;
            status_seen[r.status]++;
            n_requests++;
            pending_q.push_back(r);
        endfunction

        function void flag_field(string name, longint want, longint got);
            n_errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        endfunction

        function void check_result(logic [47:0] tdata, logic [1:0] tuser);
            t_result want;
            if (pending_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, nothing pending: tdata %0h tuser %0h",
                         $time, tdata, tuser);
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (tuser !== want.status) flag_field("status", want.status, tuser);
            if (tdata[31:0] !== want.data) flag_field("data_out", want.data, tdata[31:0]);
            if (tdata[38:32] !== want.fpos)
                flag_field("found_position", want.fpos, tdata[38:32]);
            if (tdata[45:39] !== want.count) flag_field("list_count", want.count, tdata[45:39]);
            if (tdata[46] !== want.empty) flag_field("is_empty", want.empty, tdata[46]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data = '0;   // position[6:0], value[38:7], zero pad
    logic [2:0]  s_user = '0;   // kind[2:0]
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata; // data_out[31:0], found_position[38:32],
                                 // list_count[45:39], is_empty[46], zero pad
    logic [1:0]  o_m_axis_tuser; // status[1:0]

    list_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    n_holds = 0;
    bit             src_calm = 1'b0;
    bit             sink_calm = 1'b0;
    bit             hold_off = 1'b0;

    sequential_list_engine_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // offer one request item, returns at the edge where it is taken
    task automatic offer_request(input logic [2:0] kind, input logic [6:0] pos,
                                 input t_elem val);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {1'b0, val, pos};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(kind, pos, val);
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int stall;
        int taken;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 40 == 0) sink_calm = ($urandom_range(0, 2) == 0);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
                n_holds++;
            end else begin
                stall = sink_calm ? 0 : $urandom_range(0, 7);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            taken++;
        end
    end

    initial begin
        int          i;
        int          n;
        int          top;
        int          roll;
        bit          growing;
        logic [2:0]  kind;
        logic [6:0]  pos;
        t_elem       val;
        int unsigned n_directed;

        sb = new();
        growing = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: bad positions and searches that find nothing
        offer_request(K_GET,    7'd1, 32'h0);
        offer_request(K_DELETE, 7'd0, 32'h0);
        offer_request(K_NEXT,   7'd0, 32'h0);
        offer_request(K_PRIOR,  7'd0, 32'h0);
        offer_request(K_LOCATE, 7'd0, 32'h0);
        offer_request(K_INSERT, 7'd0, 32'h5);
        offer_request(K_INSERT, 7'd2, 32'h5);
        // build 0, -1, min, max
        offer_request(K_INSERT, 7'd1, 32'h8000_0000);
        offer_request(K_INSERT, 7'd2, 32'h7fff_ffff);
        offer_request(K_INSERT, 7'd1, 32'h0);
        offer_request(K_INSERT, 7'd2, 32'hffff_ffff);
        offer_request(K_LOCATE, 7'd0, 32'h7fff_ffff);
        offer_request(K_LOCATE, 7'd0, 32'd12345);
        offer_request(K_PRIOR,  7'd0, 32'h0);           // head has no predecessor
        offer_request(K_PRIOR,  7'd0, 32'h8000_0000);
        offer_request(K_NEXT,   7'd0, 32'h7fff_ffff);   // tail has no successor
        offer_request(K_NEXT,   7'd0, 32'h0);
        offer_request(K_GET,    7'd4, 32'h0);
        offer_request(K_GET,    7'd5, 32'h0);
        offer_request(K_DELETE, 7'd4, 32'h0);
        offer_request(K_DELETE, 7'd1, 32'h0);
        offer_request(KIND_UNUSED, 7'd127, 32'hffff_ffff);
        offer_request(K_INSERT, 7'd127, 32'hffff_ffff);
        offer_request(K_CLEAR,  7'd0, 32'h0);
        offer_request(K_GET,    7'd1, 32'h0);
        n_directed = sb.n_requests;

        // fill toward capacity, linger at full, then drain back down
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            n = sb.len;
            if (i % 50 == 0) src_calm = ($urandom_range(0, 2) == 0);
            if (i == RANDOM_ITEMS / 2) hold_off = 1'b1;
            if (growing && n == CAPACITY && $urandom_range(0, 5) == 0) growing = 1'b0;
            else if (!growing && n == 0) growing = 1'b1;

            roll = $urandom_range(0, 99);
            if (roll < 2) kind = growing ? K_GET : K_CLEAR;
            else if (roll < 4) kind = KIND_UNUSED;
            else if (roll < 16) kind = K_GET;
            else if (roll < 28) kind = K_LOCATE;
            else if (roll < 38) kind = K_PRIOR;
            else if (roll < 48) kind = K_NEXT;
            else if (roll < (growing ? 94 : 63)) kind = K_INSERT;
            else kind = K_DELETE;

            top = (kind == K_INSERT) ? n + 1 : n;
            if (top == 0 || $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: pos = 7'd0;
                    1: pos = 7'(top + 1);
                    default: pos = 7'($urandom_range(0, 65));
                endcase
            end else begin
                pos = 7'($urandom_range(1, top));
            end

            // mostly stored or small values so searches hit and duplicates occur
            roll = $urandom_range(0, 99);
            if (n > 0 && roll < 35) val = sb.elems[$urandom_range(0, n - 1)];
            else if (roll < 75) val = $urandom_range(0, 15) - 8;
            else val = $urandom();

            offer_request(kind, pos, val);
        end
        s_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d requests (%0d directed), checked %0d results, longest list %0d",
                 sb.n_requests, n_directed, sb.n_checked, sb.max_len);
        $display("ok %0d, bad position %0d, not found %0d, full %0d, receiver hold-offs %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BADPOS],
                 sb.status_seen[ST_NOTFOUND], sb.status_seen[ST_FULL], n_holds);
        if (sb.n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
